>>> design/dcrf_pkg.sv
// Shared constants and control/status types for the dirty cell run framer.
`default_nettype none

package dcrf_pkg;

	// Screen geometry and run shaping
	localparam int ROW_CELLS     = 32;
	localparam int ROW_COUNT     = 24;
	localparam int GAP_LOOKAHEAD = 3;
	localparam int RUN_DEPTH     = 32;

	// Lookahead line holds the cell being judged plus the cells after it
	localparam int LINE_DEPTH = GAP_LOOKAHEAD + 1;
	localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int FILL_W     = $clog2(LINE_DEPTH + 1);

	// Run buffer addressing and run counter
	localparam int RUN_AW = $clog2(RUN_DEPTH);
	localparam int RUN_CW = $clog2(RUN_DEPTH + 1);

	// Field widths
	localparam int BYTE_W = 8;
	localparam int ENT_W  = 2 * BYTE_W + 1;  // {changed, colour, glyph}
	localparam int REC_W  = 2 * BYTE_W;      // {colour, glyph}

	typedef struct packed {
		logic load;        // take the incoming cell into the lookahead line
		logic judge;       // judge the pending entry at the judge index
		logic finish;      // per-cell bookkeeping: shift line, step counters
		logic load_hdr;    // put a header record into the output register
		logic load_cell;   // put the next buffered cell record into the output register
		logic frame_done;  // last record of the frame loaded: close the run
	} cmd_t;

	typedef struct packed {
		logic judge_due;   // an entry still has to be judged for this beat
		logic judge_close; // the entry under judgement ends the open run
		logic row_end;     // the current beat is the last cell of a row
		logic in_run;      // a run is open
		logic hdr_last;    // the header is the whole frame (empty run)
		logic cell_last;   // the next cell record is the last of the frame
		logic out_free;    // the output register can take a record this cycle
	} status_t;

endpackage

`default_nettype wire

>>> design/dcrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dcrf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> design/dcrf_ctrl.sv
// Controller state machine: sequences load, judging, frame emission and bookkeeping.
`default_nettype none

module dcrf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output dcrf_pkg::cmd_t        cmd,
	input  wire dcrf_pkg::status_t status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_JUDGE,
		S_HDR,
		S_CELL
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_JUDGE;
				end
			end
			S_JUDGE: begin
				if (status.judge_due) begin
					cmd.judge = 1'b1;
					if (status.judge_close) begin
						state_d = S_HDR;
					end else if (!status.row_end) begin
						// mid-row: one judgement per beat, bookkeeping alongside
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end else if (status.row_end && status.in_run) begin
					state_d = S_HDR;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_HDR: begin
				if (status.out_free) begin
					cmd.load_hdr = 1'b1;
					if (status.hdr_last) begin
						cmd.frame_done = 1'b1;
						state_d        = S_JUDGE;
					end else begin
						state_d = S_CELL;
					end
				end
			end
			S_CELL: begin
				if (status.out_free) begin
					cmd.load_cell = 1'b1;
					if (status.cell_last) begin
						cmd.frame_done = 1'b1;
						state_d        = S_JUDGE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	a_rec_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_hdr || cmd.load_cell) |-> status.out_free)
		else $error("record loaded while output register occupied");

	a_done_with_record: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.frame_done |-> (cmd.load_hdr || cmd.load_cell))
		else $error("frame closed without its last record");

	a_close_enters_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.judge && status.judge_close) |=> (state_q == S_HDR))
		else $error("closing judgement did not start a frame");

endmodule

`default_nettype wire

>>> design/dcrf_dpath.sv
// Datapath: lookahead line, run tracking, run buffer and output record register.
`default_nettype none

module dcrf_dpath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dcrf_pkg::cmd_t        cmd,
	output dcrf_pkg::status_t          status,
	input  wire logic                  cfg_wr_en,
	input  wire logic                  cfg_wr_data,
	input  wire logic                  cell_changed,
	input  wire logic [7:0]            cell_color,
	input  wire logic [7:0]            cell_glyph,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       is_header,
	output logic [7:0]                 run_column,
	output logic [7:0]                 run_row,
	output logic [7:0]                 run_length,
	output logic [7:0]                 out_color,
	output logic [7:0]                 out_glyph,
	output logic                       frame_last
);

	// lookahead line
	logic [dcrf_pkg::ENT_W-1:0]  la_q [dcrf_pkg::LINE_DEPTH];
	logic [dcrf_pkg::FILL_W-1:0] fill_q;
	logic [dcrf_pkg::FILL_W-1:0] jidx_q;

	// position and run state
	logic [7:0]                  col_q;
	logic [7:0]                  row_q;
	logic                        in_run_q;
	logic [7:0]                  run_start_q;
	logic [dcrf_pkg::RUN_CW-1:0] run_count_q;
	logic [dcrf_pkg::RUN_CW-1:0] cur_q;
	logic                        full_update_q;
	logic                        out_valid_q;

	// judge path
	logic [dcrf_pkg::ENT_W-1:0]  ent_sel;
	logic                        here_own;
	logic                        ahead;
	logic [7:0]                  judge_col;
	logic                        row_end;
	logic                        do_open;
	logic                        do_take;
	logic                        room;
	logic [dcrf_pkg::RUN_CW-1:0] cur_plus;

	// run buffer ports
	logic                        ram_we;
	logic [dcrf_pkg::RUN_AW-1:0] ram_waddr;
	logic                        ram_re;
	logic [dcrf_pkg::RUN_AW-1:0] ram_raddr;
	logic [dcrf_pkg::REC_W-1:0]  ram_rdata;

	assign row_end   = (col_q >= 8'(dcrf_pkg::ROW_CELLS - 1));
	assign ent_sel   = la_q[jidx_q[dcrf_pkg::LINE_AW-1:0]];
	assign here_own  = ent_sel[dcrf_pkg::ENT_W-1] | full_update_q;
	// column of entry j of n pending: col - (n - 1 - j)
	assign judge_col = col_q + 8'(jidx_q) + 8'd1 - 8'(fill_q);
	assign room      = (run_count_q < dcrf_pkg::RUN_CW'(dcrf_pkg::RUN_DEPTH));
	assign cur_plus  = cur_q + dcrf_pkg::RUN_CW'(1);

	// lookahead uses the raw changed flags only
	always_comb begin
		ahead = 1'b0;
		for (int k = 0; k < dcrf_pkg::LINE_DEPTH; k++) begin
			if (k > int'(jidx_q) && k < int'(fill_q) &&
			    k <= int'(jidx_q) + dcrf_pkg::GAP_LOOKAHEAD) begin
				ahead = ahead | la_q[k][dcrf_pkg::ENT_W-1];
			end
		end
	end

	assign do_open = cmd.judge && !in_run_q && here_own;
	assign do_take = cmd.judge && in_run_q && (here_own || ahead);

	assign ram_we    = do_open || (do_take && room);
	assign ram_waddr = in_run_q ? run_count_q[dcrf_pkg::RUN_AW-1:0] : '0;
	assign ram_re    = cmd.load_hdr || cmd.load_cell;
	assign ram_raddr = cmd.load_hdr ? '0 : cur_plus[dcrf_pkg::RUN_AW-1:0];

	dcrf_ram #(
		.WIDTH (dcrf_pkg::REC_W),
		.DEPTH (dcrf_pkg::RUN_DEPTH)
	) u_run_buf (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ent_sel[dcrf_pkg::REC_W-1:0]),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_comb begin
		status.row_end     = row_end;
		status.in_run      = in_run_q;
		status.judge_due   = row_end ? (jidx_q < fill_q) :
		                     ((fill_q == dcrf_pkg::FILL_W'(dcrf_pkg::LINE_DEPTH)) &&
		                      (jidx_q == '0));
		status.judge_close = in_run_q && !(here_own || ahead);
		status.hdr_last    = (run_count_q == '0);
		status.cell_last   = (cur_plus == run_count_q);
		status.out_free    = !out_valid_q || !out_stall;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			jidx_q        <= '0;
			col_q         <= '0;
			row_q         <= '0;
			in_run_q      <= 1'b0;
			run_start_q   <= '0;
			run_count_q   <= '0;
			cur_q         <= '0;
			full_update_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				full_update_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				fill_q <= fill_q + dcrf_pkg::FILL_W'(1);
				jidx_q <= '0;
			end
			if (cmd.judge) begin
				jidx_q <= jidx_q + dcrf_pkg::FILL_W'(1);
			end
			if (do_open) begin
				in_run_q    <= 1'b1;
				run_start_q <= judge_col;
				run_count_q <= dcrf_pkg::RUN_CW'(1);
			end else if (do_take && room) begin
				run_count_q <= run_count_q + dcrf_pkg::RUN_CW'(1);
			end
			if (cmd.load_hdr) begin
				cur_q <= '0;
			end else if (cmd.load_cell) begin
				cur_q <= cur_plus;
			end
			if (cmd.frame_done) begin
				in_run_q    <= 1'b0;
				run_count_q <= '0;
			end
			if (cmd.finish) begin
				if (row_end) begin
					in_run_q    <= 1'b0;
					run_count_q <= '0;
					fill_q      <= '0;
					col_q       <= '0;
					row_q       <= (row_q == 8'(dcrf_pkg::ROW_COUNT - 1)) ? 8'd0 :
					               row_q + 8'd1;
				end else begin
					col_q <= col_q + 8'd1;
					if (fill_q == dcrf_pkg::FILL_W'(dcrf_pkg::LINE_DEPTH)) begin
						fill_q <= dcrf_pkg::FILL_W'(dcrf_pkg::LINE_DEPTH - 1);
					end
				end
			end
			if (ram_re) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: line entries and output record
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			la_q[fill_q[dcrf_pkg::LINE_AW-1:0]] <= {cell_changed, cell_color, cell_glyph};
		end
		if (cmd.finish && !row_end &&
		    fill_q == dcrf_pkg::FILL_W'(dcrf_pkg::LINE_DEPTH)) begin
			for (int k = 0; k < dcrf_pkg::LINE_DEPTH - 1; k++) begin
				la_q[k] <= la_q[k+1];
			end
		end
		if (cmd.load_hdr) begin
			is_header  <= 1'b1;
			run_column <= run_start_q;
			run_row    <= row_q;
			run_length <= 8'(run_count_q);
			out_color  <= 8'd0;
			out_glyph  <= 8'd0;
			frame_last <= (run_count_q == '0);
		end else if (cmd.load_cell) begin
			is_header  <= 1'b0;
			run_column <= 8'd0;
			run_row    <= 8'd0;
			run_length <= 8'd0;
			out_color  <= ram_rdata[dcrf_pkg::REC_W-1:dcrf_pkg::BYTE_W];
			out_glyph  <= ram_rdata[dcrf_pkg::BYTE_W-1:0];
			frame_last <= cur_plus == run_count_q;
		end
	end

	assign out_valid = out_valid_q;

	a_open_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q |-> (run_count_q != '0))
		else $error("open run with no buffered cells");

	a_cell_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_cell |-> (cur_plus <= run_count_q))
		else $error("cell record beyond end of run");

	a_line_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (fill_q < dcrf_pkg::FILL_W'(dcrf_pkg::LINE_DEPTH)))
		else $error("lookahead line full after bookkeeping");

endmodule

`default_nettype wire

>>> design/dirty_cell_run_framer.sv
// Top level of the dirty cell run framer: controller plus datapath.
//
//  channel  | beat handshake       | payload
//  ---------+----------------------+-----------------------------------------------
//  cell in  | in_valid / in_stall  | cell_changed, cell_color, cell_glyph
//  record   | out_valid / out_stall| is_header, run_column, run_row, run_length,
//           |                      | out_color, out_glyph, frame_last
//  config   | cfg_wr_en            | cfg_wr_data (full_update)
//
// A mid-row cell is accepted, then judged (once the line is full) with line shift and column step.
// A row's last cell is accepted, then its n <= GAP_LOOKAHEAD + 1 pending cells drain in turn.
// A closing run then emits its header and its buffered cell records, records leaving one per cycle
// while out_stall is low. arst_n clears counters, run state and output valid; the run buffer is
// never cleared. in_stall is high from accept until the beat's bookkeeping is done; out_stall
// only holds the output register and the frame sequence behind it.
`default_nettype none

module dirty_cell_run_framer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_wr_data,
	// cell beats
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       cell_changed,
	input  wire logic [7:0] cell_color,
	input  wire logic [7:0] cell_glyph,
	// record beats
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            is_header,
	output logic [7:0]      run_column,
	output logic [7:0]      run_row,
	output logic [7:0]      run_length,
	output logic [7:0]      out_color,
	output logic [7:0]      out_glyph,
	output logic            frame_last
);

	dcrf_pkg::cmd_t    cmd;
	dcrf_pkg::status_t status;

	// sequencing only; all storage and arithmetic sit in the datapath
	dcrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	dcrf_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cell_changed (cell_changed),
		.cell_color   (cell_color),
		.cell_glyph   (cell_glyph),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_header    (is_header),
		.run_column   (run_column),
		.run_row      (run_row),
		.run_length   (run_length),
		.out_color    (out_color),
		.out_glyph    (out_glyph),
		.frame_last   (frame_last)
	);

endmodule

`default_nettype wire

>>> sim/tb_dirty_cell_run_framer.sv
// Self-checking testbench for the dirty cell run framer: directed and random screen rows.
module tb_dirty_cell_run_framer;
	timeunit 1ns;
	timeprecision 1ps;

	// worst row-end beat without records: accept, line drain, a little margin
	localparam int SETTLE_CYCLES  = 2 * (dcrf_pkg::GAP_LOOKAHEAD + 3);
	// longest legal quiet stretch is the settle pause or a receiver stall streak
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 5;
	localparam int PHASE_BEATS    = 20;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	typedef struct packed {
		logic       changed;
		logic [7:0] color;
		logic [7:0] glyph;
	} screen_cell_t;

	typedef struct packed {
		logic       is_header;
		logic [7:0] column;
		logic [7:0] row;
		logic [7:0] length;
		logic [7:0] color;
		logic [7:0] glyph;
		logic       last;
	} run_record_t;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       cfg_wr_en    = 1'b0;
	logic       cfg_wr_data  = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic       cell_changed = 1'b0;
	logic [7:0] cell_color   = '0;
	logic [7:0] cell_glyph   = '0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic       is_header;
	logic [7:0] run_column;
	logic [7:0] run_row;
	logic [7:0] run_length;
	logic [7:0] out_color;
	logic [7:0] out_glyph;
	logic       frame_last;

	dirty_cell_run_framer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cell_changed (cell_changed),
		.cell_color   (cell_color),
		.cell_glyph   (cell_glyph),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_header    (is_header),
		.run_column   (run_column),
		.run_row      (run_row),
		.run_length   (run_length),
		.out_color    (out_color),
		.out_glyph    (out_glyph),
		.frame_last   (frame_last)
	);

	// 20 ns period; inputs move on the falling edge, beats are taken on the rising one
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Screen tracker: own copy of the lookahead line, run buffer, counters
	// and the full-update bit. Fed once per accepted cell beat; fills
	// due_records with every record the framer owes us, in order.
	// ------------------------------------------------------------------
	screen_cell_t look_line [dcrf_pkg::GAP_LOOKAHEAD + 1];
	int unsigned  look_fill   = 0;
	logic [15:0]  run_cells [dcrf_pkg::RUN_DEPTH];
	int unsigned  scan_col    = 0;
	int unsigned  scan_row    = 0;
	bit           run_open    = 1'b0;
	int unsigned  run_col     = 0;
	int unsigned  run_len     = 0;
	bit           full_update = 1'b0;
	run_record_t  due_records [$];

	// header first, then one record per buffered cell; last one flagged
	task automatic close_run();
		run_record_t rec;
		rec           = '0;
		rec.is_header = 1'b1;
		rec.column    = 8'(run_col);
		rec.row       = 8'(scan_row);
		rec.length    = 8'(run_len);
		rec.last      = (run_len == 0);
		due_records.push_back(rec);
		for (int unsigned i = 0; i < run_len; i++) begin
			rec       = '0;
			rec.color = run_cells[i][15:8];
			rec.glyph = run_cells[i][7:0];
			rec.last  = (i + 1 == run_len);
			due_records.push_back(rec);
		end
		run_open = 1'b0;
		run_len  = 0;
	endtask

	// cells past the buffer depth are dropped, the run stays open
	task automatic take_into_run(input screen_cell_t c);
		if (run_len < dcrf_pkg::RUN_DEPTH) begin
			run_cells[run_len] = {c.color, c.glyph};
			run_len++;
		end
	endtask

	// Decide the fate of one pending entry. full_update is read here, at
	// judgement, so a register write lands on cells already in the line.
	task automatic judge_entry(input int unsigned idx, input int unsigned n,
			input int unsigned col);
		bit worth_sending;
		worth_sending = look_line[idx].changed || full_update;
		if (!run_open) begin
			if (worth_sending) begin
				run_open = 1'b1;
				run_col  = col;
				run_len  = 0;
				take_into_run(look_line[idx]);
			end
		end else begin
			// only the changed flags of later cells of this row keep the run alive
			for (int unsigned j = idx + 1; j < n && j <= idx + dcrf_pkg::GAP_LOOKAHEAD; j++)
				if (look_line[j].changed)
					worth_sending = 1'b1;
			if (worth_sending)
				take_into_run(look_line[idx]);
			else
				close_run();
		end
	endtask

	task automatic track_cell(input screen_cell_t c);
		int unsigned n;
		look_line[look_fill] = c;
		n = look_fill + 1;
		if (scan_col == dcrf_pkg::ROW_CELLS - 1) begin
			// row end: drain the whole line, then force any open run shut
			for (int unsigned i = 0; i < n; i++)
				judge_entry(i, n, scan_col - (n - 1 - i));
			if (run_open)
				close_run();
			look_fill = 0;
			scan_col  = 0;
			scan_row  = (scan_row + 1 >= dcrf_pkg::ROW_COUNT) ? 0 : scan_row + 1;
		end else begin
			if (n > dcrf_pkg::GAP_LOOKAHEAD) begin
				judge_entry(0, n, scan_col - (n - 1));
				for (int unsigned i = 1; i < n; i++)
					look_line[i - 1] = look_line[i];
				look_fill = n - 1;
			end else begin
				look_fill = n;
			end
			scan_col++;
		end
	endtask

	// ------------------------------------------------------------------
	// Mismatch reporting and record checking
	// ------------------------------------------------------------------
	int unsigned mismatches   = 0;
	int unsigned records_seen = 0;

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			flag_mismatch($sformatf("record %0d %s got %0h expected %0h",
				records_seen, name, got, want));
	endtask

	task automatic check_record();
		run_record_t want;
		if (due_records.size() == 0) begin
			flag_mismatch($sformatf("record %0d arrived with none due", records_seen));
		end else begin
			want = due_records.pop_front();
			check_field("is_header", is_header, want.is_header);
			check_field("run_column", run_column, want.column);
			check_field("run_row", run_row, want.row);
			check_field("run_length", run_length, want.length);
			check_field("out_color", out_color, want.color);
			check_field("out_glyph", out_glyph, want.glyph);
			check_field("frame_last", frame_last, want.last);
		end
		records_seen++;
	endtask

	// record beat taken when valid and not stalled at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_record();
	end

	// ------------------------------------------------------------------
	// Receiver stall pattern: a fresh 16-bit mask whenever the last one is used up,
	// bit 0 always clear so a stall streak never runs on from one mask into the next.
	// ------------------------------------------------------------------
	stall_mode_t stall_mode = STALL_NONE;
	logic [15:0] stall_bits = '0;
	int unsigned stall_step = 0;

	always @(negedge clk) begin
		if (stall_step % 16 == 0) begin
			case (stall_mode)
				STALL_NONE:  stall_bits = '0;
				STALL_LIGHT: stall_bits = 16'($urandom & $urandom) & 16'hfffe;
				STALL_HEAVY: stall_bits = 16'($urandom) & 16'hfffe;
				default:     stall_bits = '0;
			endcase
		end
		out_stall <= stall_bits[stall_step % 16];
		stall_step++;
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with no beat on either channel ends the run
	// ------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender: bursts of random length with random gaps, when enabled
	// ------------------------------------------------------------------
	bit          sender_gaps = 1'b0;
	int unsigned burst_left  = 0;

	task automatic set_pressure(input bit gaps, input stall_mode_t mode);
		sender_gaps = gaps;
		burst_left  = 0;
		stall_mode  = mode;
	endtask

	// Called at a falling edge. Valid is left high when the next beat
	// follows straight on, so it is never dropped and raised in one step.
	task automatic send_beat(input logic changed, input logic [7:0] color,
			input logic [7:0] glyph);
		screen_cell_t c;
		c.changed    = changed;
		c.color      = color;
		c.glyph      = glyph;
		in_valid     <= 1'b1;
		cell_changed <= changed;
		cell_color   <= color;
		cell_glyph   <= glyph;
		do
			@(posedge clk);
		while (in_stall);
		track_cell(c);
		@(negedge clk);
		if (sender_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(12, 1);
				in_valid   <= 1'b0;
				repeat ($urandom_range(6, 1)) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// unchanged filler cells up to a given screen position
	task automatic pad_quiet_to(input int unsigned row, input int unsigned col);
		while (scan_row != row || scan_col != col)
			send_beat(1'b0, 8'($urandom), 8'($urandom));
	endtask

	// all records in, then time for a record-less beat still in the line drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (due_records.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_full_update(input bit value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		full_update = value;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Row 0: a gap the lookahead spans, a gap one cell too long, a lone
	// cell run, and a run still open when the row ends.
	task automatic test_lookahead_bridging();
		set_pressure(1'b1, STALL_LIGHT);
		send_beat(1'b1, 8'hff, 8'h00);
		repeat (dcrf_pkg::GAP_LOOKAHEAD) send_beat(1'b0, 8'h00, 8'hff);
		send_beat(1'b1, 8'h80, 8'h01);
		repeat (dcrf_pkg::GAP_LOOKAHEAD + 1) send_beat(1'b0, 8'h7f, 8'hfe);
		send_beat(1'b1, 8'h00, 8'hff);
		repeat (dcrf_pkg::GAP_LOOKAHEAD + 1) send_beat(1'b0, 8'h55, 8'haa);
		pad_quiet_to(0, dcrf_pkg::ROW_CELLS - 4);
		send_beat(1'b1, 8'h01, 8'h80);
		send_beat(1'b0, 8'haa, 8'h55);
		send_beat(1'b1, 8'hfe, 8'h7f);
		send_beat(1'b1, 8'hff, 8'hff);
	endtask

	// Runs that open and close inside the row-end drain, and a one-cell
	// run sitting on the last column.
	task automatic test_row_end_drain();
		set_pressure(1'b1, STALL_HEAVY);
		pad_quiet_to(1, dcrf_pkg::ROW_CELLS - 3);
		send_beat(1'b1, 8'h3c, 8'hc3);
		send_beat(1'b0, 8'h00, 8'h00);
		send_beat(1'b0, 8'hff, 8'hff);
		pad_quiet_to(2, dcrf_pkg::ROW_CELLS - 1);
		send_beat(1'b1, 8'hc3, 8'h3c);
	endtask

	// Full update switched on with cells already waiting in the line: they
	// are judged under the new setting, giving a whole-row run that fills
	// the run buffer. Then switched off again over waiting cells.
	task automatic test_full_update_switch();
		set_pressure(1'b0, STALL_NONE);
		send_beat(1'b0, 8'h12, 8'h34);
		send_beat(1'b0, 8'h56, 8'h78);
		write_full_update(1'b1);
		set_pressure(1'b1, STALL_LIGHT);
		pad_quiet_to(4, 0);
		send_beat(1'b0, 8'h9a, 8'hbc);
		send_beat(1'b1, 8'hde, 8'hf0);
		send_beat(1'b0, 8'h0f, 8'hed);
		write_full_update(1'b0);
		pad_quiet_to(4, dcrf_pkg::ROW_CELLS / 2);
		send_beat(1'b1, 8'hcb, 8'ha9);
		pad_quiet_to(5, 0);
	endtask

	// Random rows built from streaks of changed and unchanged cells, gap
	// lengths straddling the lookahead, with a little noise. full_update
	// flips between phases, which end at arbitrary columns.
	task automatic test_random_rows();
		bit          dirty_streak;
		int unsigned streak_left;
		logic        changed;
		dirty_streak = 1'b0;
		streak_left  = 0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_full_update((phase % 2) != 0);
			// first phase runs flat out on both sides
			if (phase == 0)
				set_pressure(1'b0, STALL_NONE);
			else
				set_pressure($urandom_range(1, 0) != 0,
					stall_mode_t'($urandom_range(2, 0)));
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (streak_left == 0) begin
					dirty_streak = !dirty_streak;
					streak_left  = dirty_streak ? $urandom_range(8, 1)
						: $urandom_range(dcrf_pkg::GAP_LOOKAHEAD + 3, 1);
				end
				changed = dirty_streak ^ ($urandom_range(15, 0) == 0);
				send_beat(changed, 8'($urandom), 8'($urandom));
				streak_left--;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_full_update(1'b0);
		test_lookahead_bridging();
		test_row_end_drain();
		test_full_update_switch();
		test_random_rows();
		wait_idle();
		// room for any stray record beyond the last one due
		repeat (dcrf_pkg::RUN_DEPTH + SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> dirty_cell_run_framer.f
design/dcrf_pkg.sv
design/dcrf_ram.sv
design/dcrf_ctrl.sv
design/dcrf_dpath.sv
design/dirty_cell_run_framer.sv
sim/tb_dirty_cell_run_framer.sv
